>>> hdl/tlru_pkg.sv
// Shared constants and types for the timestamp LRU victim select block.
// Used by tlru_min_scan and timestamp_lru_victim_select_core.
`default_nettype none

package tlru_pkg;

    // Cache geometry: both are powers of two, SETS at most 2048 (11-bit set field)
    localparam int SETS   = 2048;
    localparam int WAYS   = 16;
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int ADDR_W = SET_W + WAY_W;

    // Stamp and counter widths
    localparam int STAMP_W = 64;
    localparam int LOW_W   = 20;

    // Item field widths
    localparam int MODE_W   = 2;
    localparam int SETF_W   = 11;
    localparam int WAYF_W   = 4;
    localparam int VICT_W   = 4;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 5;
    localparam int M_DATA_W = 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_LOW_LIMIT = '0;
    localparam logic [LOW_W-1:0]   LOW_LIMIT_RST = LOW_W'(1000);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

    localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = '1;

    // One stamp read handed to the minimum scan unit
    typedef struct packed {
        logic             vld;
        logic             first;
        logic [WAY_W-1:0] way;
    } t_scan_in;

endpackage

`default_nettype wire

>>> hdl/tlru_min_scan.sv
// Shared 64-bit compare unit: tracks the lowest stamp over one set, one way a cycle.
// Depends on tlru_pkg.
`default_nettype none

module tlru_min_scan (
    input  wire logic                          i_clk,
    input  wire tlru_pkg::t_scan_in            i_scan,
    input  wire logic [tlru_pkg::STAMP_W-1:0]  i_stamp,
    output logic      [tlru_pkg::WAY_W-1:0]    o_best_way
);
    import tlru_pkg::*;

    logic [STAMP_W-1:0] r_best_stamp;
    logic [WAY_W-1:0]   r_best_way;

    // strict less-than keeps the lowest way index on ties
    always_ff @(posedge i_clk) begin
        if (i_scan.vld && (i_scan.first || (i_stamp < r_best_stamp))) begin
            r_best_stamp <= i_stamp;
            r_best_way   <= i_scan.way;
        end
    end

    assign o_best_way = r_best_way;

endmodule

`default_nettype wire

>>> hdl/timestamp_lru_victim_select_core.sv
// Top level of the timestamp LRU victim select block: stamp memory, sequencer, APB register.
// Depends on tlru_pkg and tlru_min_scan.
`default_nettype none

// Channel   Dir  Contents
// s_axis    in   tdata: set_index, way_index; tuser: mode, fill_requested, is_hit, is_write
// m_axis    out  tdata: victim_way
// apb       in   low_stamp_limit at byte address 0
//
// Victim request: the set's stamps are read one way a cycle through the single
// memory read port (S_SCAN), then S_DRAIN and S_VWR; S_VWR waits for the output register.
// Fill and access update: one memory write in S_UPD, then back to idle.
// After reset a clearing pass writes every stamp to zero; no item is accepted
// meanwhile, register writes are.
// A finished victim waits in the output register; a new item is taken meanwhile.

module timestamp_lru_victim_select_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input items
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [10:0] set_index, [14:11] way_index, [15] zero
    input  wire logic [tlru_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] mode, [2] fill_requested, [3] is_hit, [4] is_write
    input  wire logic [tlru_pkg::S_USER_W-1:0]  s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [3:0] victim_way, [7:4] zero
    output logic      [tlru_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tlru_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tlru_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tlru_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);
    import tlru_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_UPD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_VWR   = 6'b100000
    } t_state;

    localparam logic [WAY_W-1:0]  WAY_LAST  = WAY_W'(WAYS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SETS * WAYS - 1);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [WAY_W-1:0]    r_cnt, n_cnt;
    logic                r_rd_vld;
    logic [WAY_W-1:0]    r_rd_way;
    logic [STAMP_W-1:0]  r_recency, n_recency;
    logic [LOW_W-1:0]    r_low_cnt, n_low_cnt;
    logic [LOW_W-1:0]    r_low_limit;
    logic                r_out_vld, n_out_vld;
    logic [VICT_W-1:0]   r_out_way, n_out_way;

    // latched item
    logic [SET_W-1:0]    r_set;
    logic [WAY_W-1:0]    r_way;
    logic [MODE_W-1:0]   r_mode;
    logic                r_req, r_hit, r_wr;

    // stamp memory
    logic [STAMP_W-1:0]  r_mem [SETS*WAYS];
    logic [STAMP_W-1:0]  r_rd_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [STAMP_W-1:0]  wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    logic                s_acc;
    logic                out_free;
    logic [WAY_W-1:0]    best_way;
    t_scan_in            scan_in;
    logic [SETF_W-1:0]   in_set;
    logic [WAYF_W-1:0]   in_way;
    logic                low_wrap;
    logic                cfg_wr;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign in_set        = s_axis_tdata[SETF_W-1:0];
    assign in_way        = s_axis_tdata[SETF_W+WAYF_W-1:SETF_W];
    assign low_wrap      = (r_low_cnt >= r_low_limit);
    assign rd_addr       = {r_set, r_cnt};

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_LOW_LIMIT);

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_LOW_LIMIT) begin
            prdata = PDATA_W'(r_low_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit <= LOW_LIMIT_RST;
        end else if (cfg_wr) begin
            r_low_limit <= pwdata[LOW_W-1:0];
        end
    end

    // sequencer and memory write port
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cnt      = r_cnt;
        n_recency  = r_recency;
        n_low_cnt  = r_low_cnt;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_way  = r_out_way;
        mem_we     = 1'b0;
        wr_addr    = {r_set, r_way};
        wr_data    = r_recency;

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_cnt = '0;
                    if (s_axis_tuser[MODE_W-1:0] == MODE_VICTIM) begin
                        n_state = S_SCAN;
                    end else if (s_axis_tuser[MODE_W-1:0] == MODE_FILL
                                 || s_axis_tuser[MODE_W-1:0] == MODE_UPDATE) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                n_state = S_IDLE;
                if (r_mode == MODE_FILL && !r_req) begin
                    // low-priority fill stamp, wraps at the limit
                    mem_we    = 1'b1;
                    wr_data   = low_wrap ? '0 : STAMP_W'(r_low_cnt);
                    n_low_cnt = low_wrap ? LOW_W'(1) : r_low_cnt + 1'b1;
                end else if ((r_mode == MODE_FILL && r_req)
                             || (r_mode == MODE_UPDATE && r_hit && !r_wr)) begin
                    mem_we    = 1'b1;
                    wr_data   = r_recency;
                    n_recency = r_recency + 1'b1;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WAY_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_VWR;
            end
            S_VWR: begin
                // wait for the output register, then retire the victim
                if (out_free) begin
                    mem_we    = 1'b1;
                    wr_addr   = {r_set, best_way};
                    wr_data   = STAMP_ALL_ONES;
                    n_out_vld = 1'b1;
                    n_out_way = VICT_W'(best_way);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_recency  <= '0;
            r_low_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cnt      <= n_cnt;
            r_rd_vld   <= (r_state == S_SCAN);
            r_recency  <= n_recency;
            r_low_cnt  <= n_low_cnt;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_way <= n_out_way;
        r_rd_way  <= r_cnt;
        if (s_acc) begin
            r_set  <= in_set[SET_W-1:0];
            r_way  <= in_way[WAY_W-1:0];
            r_mode <= s_axis_tuser[MODE_W-1:0];
            r_req  <= s_axis_tuser[2];
            r_hit  <= s_axis_tuser[3];
            r_wr   <= s_axis_tuser[4];
        end
    end

    // stamp memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // lowest-stamp search over the set
    assign scan_in.vld   = r_rd_vld;
    assign scan_in.first = (r_rd_way == '0);
    assign scan_in.way   = r_rd_way;

    tlru_min_scan u_min_scan (
        .i_clk      (i_clk),
        .i_scan     (scan_in),
        .i_stamp    (r_rd_data),
        .o_best_way (best_way)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_DATA_W'(r_out_way);

    // no memory write while a set is being scanned
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DRAIN) |-> !mem_we)
        else $error("stamp write during victim scan");

    // a victim request starts a scan at way zero
    a_victim_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tuser[MODE_W-1:0] == MODE_VICTIM)
        |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("victim request did not start a scan");

    // read data reaches the compare unit only in the cycle after a scan read
    a_read_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_SCAN))
        else $error("compare strobe without a scan read");

    // the output register is loaded only when it is free
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VWR && mem_we) |-> (!r_out_vld || m_axis_tready))
        else $error("victim result overwrote a pending item");

endmodule

`default_nettype wire

>>> test/tb_timestamp_lru_victim_select_core.sv
// Self-checking testbench for timestamp_lru_victim_select_core: directed table, then random items.
// Depends on tlru_pkg and the core RTL; keeps its own model of stamps and counters.
`timescale 1ns / 100ps

module tb_timestamp_lru_victim_select_core;
    import tlru_pkg::*;

    localparam int DRAIN_CYCLES = WAYS + 8;
    localparam int PHASE_ITEMS  = 225;

    // Mode code with no operation behind it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One input item: mode, then set, way and the three tuser flags
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SETF_W-1:0] set_idx;
        logic [WAYF_W-1:0] way_idx;
        logic              fill_req;
        logic              is_hit;
        logic              is_write;
    } t_cache_op;

    // Directed row: item plus an optional hand-typed victim
    typedef struct packed {
        t_cache_op         op;
        logic              typed;
        logic [VICT_W-1:0] want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [S_USER_W-1:0] s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow state of the replacement logic
    logic [STAMP_W-1:0] stamp_mem [int];
    logic [STAMP_W-1:0] recency_ctr;
    logic [LOW_W-1:0]   low_ctr;
    logic [LOW_W-1:0]   low_limit;

    logic [VICT_W-1:0]  expected_victims [$];
    t_dir_row           dir_rows [$];
    int                 mismatches;
    int                 in_idle_pct;
    int                 out_stall_pct;
    bit                 quiet;

    timestamp_lru_victim_select_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [STAMP_W-1:0] stamp_at(input int slot);
        return stamp_mem.exists(slot) ? stamp_mem[slot] : '0;
    endfunction

    // Apply one accepted item to the shadow state; victim requests return a way
    function automatic bit lru_apply(input t_cache_op op, output logic [VICT_W-1:0] way_out);
        int base;
        int best;
        int slot;
        base    = int'(op.set_idx) % SETS * WAYS;
        slot    = base + int'(op.way_idx) % WAYS;
        way_out = '0;
        case (op.mode)
            MODE_VICTIM: begin
                best = 0;
                for (int w = 1; w < WAYS; w++) begin
                    if (stamp_at(base + w) < stamp_at(base + best))
                        best = w;
                end
                stamp_mem[base + best] = STAMP_ALL_ONES;
                way_out = VICT_W'(best);
                return 1'b1;
            end
            MODE_FILL: begin
                if (op.fill_req) begin
                    stamp_mem[slot] = recency_ctr;
                    recency_ctr++;
                end else begin
                    if (low_ctr >= low_limit)
                        low_ctr = '0;
                    stamp_mem[slot] = STAMP_W'(low_ctr);
                    low_ctr++;
                end
            end
            MODE_UPDATE: begin
                if (op.is_hit && !op.is_write) begin
                    stamp_mem[slot] = recency_ctr;
                    recency_ctr++;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_cache_op mk_op(input logic [MODE_W-1:0] mode, input int set_idx,
                                        input int way_idx, input bit req, input bit hit,
                                        input bit wr);
        t_cache_op op;
        op.mode     = mode;
        op.set_idx  = SETF_W'(set_idx);
        op.way_idx  = WAYF_W'(way_idx);
        op.fill_req = req;
        op.is_hit   = hit;
        op.is_write = wr;
        return op;
    endfunction

    task automatic add_row(input t_cache_op op, input bit typed, input int want);
        t_dir_row row;
        row.op    = op;
        row.typed = typed;
        row.want  = VICT_W'(want);
        dir_rows.push_back(row);
    endtask

    // Random item: mostly traffic on a few hot sets so victims see earlier fills
    function automatic t_cache_op rand_op(input logic [SETF_W-1:0] hot0,
                                          input logic [SETF_W-1:0] hot1,
                                          input logic [SETF_W-1:0] hot2);
        t_cache_op op;
        int        pick;
        op.mode     = MODE_W'($urandom_range(3, 0));
        op.set_idx  = SETF_W'($urandom);
        op.way_idx  = WAYF_W'($urandom);
        op.fill_req = 1'($urandom);
        op.is_hit   = 1'($urandom);
        op.is_write = 1'($urandom);
        if ($urandom_range(99) < 15)
            return op;
        case ($urandom_range(2))
            0:       op.set_idx = hot0;
            1:       op.set_idx = hot1;
            default: op.set_idx = hot2;
        endcase
        pick = $urandom_range(99);
        if (pick < 35)
            op.mode = MODE_VICTIM;
        else if (pick < 75)
            op.mode = MODE_FILL;
        else if (pick < 97) begin
            op.mode     = MODE_UPDATE;
            op.is_hit   = ($urandom_range(99) < 70);
            op.is_write = ($urandom_range(99) < 30);
        end
        return op;
    endfunction

    // Offer one item at the falling edge, hold until accepted
    task automatic send_op(input t_cache_op op, input bit typed, input logic [VICT_W-1:0] want);
        logic [VICT_W-1:0] got;
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < in_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({op.way_idx, op.set_idx});
        s_axis_tuser  <= {op.is_write, op.is_hit, op.fill_req, op.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        if (lru_apply(op, got))
            expected_victims.push_back(typed ? want : got);
    endtask

    // Wait for every result, then for any fill still in flight
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_victims.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_low_limit(input logic [LOW_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LOW_LIMIT, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        low_limit = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random stall bursts on tready
    initial begin
        int stall;
        stall         = 0;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall == 0 && !quiet && $urandom_range(99) < out_stall_pct)
                stall = $urandom_range(6, 1);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expected victim
    always @(posedge i_clk) begin : check_results
        logic [VICT_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_victims.size() == 0) begin
                $error("victim_way: unexpected result %0d", m_axis_tdata[VICT_W-1:0]);
                mismatches++;
            end else begin
                want = expected_victims.pop_front();
                if (m_axis_tdata[VICT_W-1:0] !== want) begin
                    $error("victim_way: expected %0d, actual %0d", want,
                           m_axis_tdata[VICT_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #6_400_000;
        $display("timestamp_lru_victim_select_core verification failed");
        $finish;
    end

    initial begin
        logic [LOW_W-1:0]  phase_limits [7];
        logic [SETF_W-1:0] hot [3];
        t_dir_row          row;
        phase_limits  = '{LOW_W'(1000000), LOW_W'(3), LOW_W'(0), LOW_W'(1), '1, LOW_W'(5),
                          LOW_LIMIT_RST};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        in_idle_pct   = 25;
        out_stall_pct = 25;
        quiet         = 1'b0;
        recency_ctr   = '0;
        low_ctr       = '0;
        low_limit     = LOW_LIMIT_RST;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reset state, extreme sets and ways, every mode
        add_row(mk_op(MODE_VICTIM, 0, 0, 0, 0, 0), 1, 0);
        add_row(mk_op(MODE_VICTIM, 0, 9, 1, 1, 1), 1, 1);
        add_row(mk_op(MODE_VICTIM, 2047, 15, 0, 0, 0), 1, 0);
        add_row(mk_op(MODE_FILL, 2047, 15, 1, 0, 0), 0, 0);
        add_row(mk_op(MODE_VICTIM, 2047, 0, 0, 0, 0), 1, 1);
        add_row(mk_op(MODE_UPDATE, 0, 0, 0, 1, 0), 0, 0);
        // writeback hit and a miss leave the stamp alone
        add_row(mk_op(MODE_UPDATE, 0, 2, 1, 1, 1), 0, 0);
        add_row(mk_op(MODE_UPDATE, 0, 3, 1, 0, 0), 0, 0);
        // unused mode does nothing
        add_row(mk_op(MODE_UNUSED, 2047, 15, 1, 1, 1), 0, 0);
        add_row(mk_op(MODE_VICTIM, 0, 0, 0, 0, 0), 1, 2);
        add_row(mk_op(MODE_FILL, 'h555, 10, 0, 1, 1), 0, 0);
        add_row(mk_op(MODE_FILL, 'h555, 0, 0, 0, 0), 0, 0);
        add_row(mk_op(MODE_VICTIM, 'h555, 5, 1, 0, 1), 0, 0);
        add_row(mk_op(MODE_FILL, 'h2AA, 5, 1, 1, 1), 0, 0);
        add_row(mk_op(MODE_UPDATE, 'h2AA, 15, 0, 1, 0), 0, 0);
        add_row(mk_op(MODE_VICTIM, 'h2AA, 0, 0, 0, 0), 0, 0);
        add_row(mk_op(MODE_VICTIM, 'h2AA, 0, 0, 0, 0), 0, 0);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_op(row.op, row.typed, row.want);
        end
        drain();

        // Random phases, one limit setting each; the last runs without idling
        foreach (phase_limits[ph]) begin
            write_low_limit(phase_limits[ph]);
            quiet         = (ph == 6);
            in_idle_pct   = (ph % 3 == 0) ? 0 : 10 * (ph % 3) + 5;
            out_stall_pct = (ph % 2 == 0) ? 30 : 10;
            hot[0]        = SETF_W'($urandom);
            hot[1]        = SETF_W'($urandom);
            hot[2]        = (ph % 2 == 0) ? '1 : '0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_op(rand_op(hot[0], hot[1], hot[2]), 1'b0, '0);
            drain();
        end

        if (mismatches == 0)
            $display("timestamp_lru_victim_select_core verification clean");
        else
            $display("timestamp_lru_victim_select_core verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/tlru_pkg.sv
hdl/tlru_min_scan.sv
hdl/timestamp_lru_victim_select_core.sv
test/tb_timestamp_lru_victim_select_core.sv
